### design/vpv_pkg.sv
// shared types and constants of the vortex particle velocity core
package vpv_pkg;

  // default depth of the particle store
  localparam int unsigned MAX_PARTICLES_DEF = 256;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_STRENGTH_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PARTICLE_COUNT = 2'd1;

  // actions
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // arithmetic constants
  localparam logic [31:0] ONE_Q30        = 32'h4000_0000;
  localparam logic [31:0] STRENGTH_RESET = 32'h0001_0000;
  localparam logic [67:0] RLEN2_MIN      = 68'd43;
  localparam logic [33:0] RHO_DIV        = 34'd10000000000;
  localparam logic [64:0] TERM_CAP       = 65'h100_0000_0000;
  localparam logic [33:0] RECIP3         = 34'd174763;

  // one input item
  typedef struct packed {
    logic               action;
    logic [7:0]         slot;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic signed [31:0] vort_x;
    logic signed [31:0] vort_y;
    logic signed [31:0] vort_z;
    logic [30:0]        radius;
    logic               mark_deleted;
  } in_item_t;

  // one result item
  typedef struct packed {
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
  } out_item_t;

endpackage

### design/vortex_particle_velocity_core.sv
// vortex particle velocity core: particle store, sequencer and shared multiplier
//
// Input channel (in_valid/in_ready/in_data) carries loads and queries. A load
// writes one particle record into the store and gives no
// result. A query walks store entries 0..particle_count-1 and returns one
// velocity transfer on the output channel (out_valid/out_ready/out_data).
// Configuration writes (cfg_valid/cfg_ready/cfg_index/cfg_data) are always taken.
// Query time is set by the one 34x34 multiplier that serves every product, the
// 26-bit restoring divider and the six squarings of the exponential. A deleted
// entry is skipped soonest, one outside the cutoff after its distance test, and
// a contributing particle takes longest.
// A marked query point gives a zero result.
// in_ready is high only while the sequencer is idle; loads are taken while a
// result waits, and a finished query holds until the output register is free.
// The output register keeps its transfer stable while out_ready is low.
// Reset (rst, synchronous) clears the sequencer, the output valid, the
// strength scale to 1.0 and the particle count to 0; the store itself is not
// cleared and must be loaded before it is queried.
module vortex_particle_velocity_core #(
  parameter int unsigned MAX_PARTICLES = vpv_pkg::MAX_PARTICLES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  vpv_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output vpv_pkg::out_item_t              out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [vpv_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                     cfg_data
);

  localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int CW = $clog2(MAX_PARTICLES + 1);

  // sequencer codes
  localparam logic [5:0] S_IDLE  = 6'd0,  S_FETCH = 6'd1,  S_RX   = 6'd2,  S_RY   = 6'd3;
  localparam logic [5:0] S_RZ    = 6'd4,  S_RS    = 6'd5,  S_S2   = 6'd6,  S_C0A  = 6'd7;
  localparam logic [5:0] S_C0B   = 6'd8,  S_C1A   = 6'd9,  S_C1B  = 6'd10, S_C2A  = 6'd11;
  localparam logic [5:0] S_C2B   = 6'd12, S_W1    = 6'd13, S_W2   = 6'd14, S_W3   = 6'd15;
  localparam logic [5:0] S_Q1    = 6'd16, S_Q2    = 6'd17, S_Q3   = 6'd18, S_Q4   = 6'd19;
  localparam logic [5:0] S_Q5    = 6'd20, S_DIV   = 6'd21, S_E1   = 6'd22, S_E2   = 6'd23;
  localparam logic [5:0] S_E3    = 6'd24, S_E4    = 6'd25, S_E5   = 6'd26, S_E6   = 6'd27;
  localparam logic [5:0] S_SQ    = 6'd28, S_SQW   = 6'd29, S_F    = 6'd30, S_FM   = 6'd31;
  localparam logic [5:0] S_TA    = 6'd32, S_TB    = 6'd33, S_TC   = 6'd34, S_FIN  = 6'd35;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vort_x;
    logic signed [31:0] vort_y;
    logic signed [31:0] vort_z;
    logic [30:0]        radius;
    logic               deleted;
  } particle_t;

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    mag33 = v[32] ? 33'(-v) : 33'(v);
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    mag32 = v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic [50:0] mag51(input logic signed [50:0] v);
    mag51 = v[50] ? 51'(-v) : 51'(v);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  // control and data registers
  logic [5:0]          state;
  logic [CW-1:0]       idx;
  logic signed [31:0]  scale;
  logic [8:0]          count;
  logic signed [31:0]  qx, qy, qz;
  particle_t           rec;
  particle_t           mem [MAX_PARTICLES];
  logic [67:0]         prod;
  logic                pneg;
  logic [67:0]         r2;
  logic [61:0]         s2;
  logic [64:0]         w2;
  logic [35:0]         csum;
  logic signed [69:0]  tmp;
  logic signed [50:0]  cv [3];
  logic [87:0]         rem, dsr;
  logic [25:0]         y;
  logic [4:0]          bitn;
  logic [21:0]         y2;
  logic [17:0]         y3;
  logic [13:0]         y4;
  logic [16:0]         t6;
  logic [30:0]         e;
  logic [2:0]          sqn;
  logic [31:0]         fm;
  logic                fneg;
  logic [1:0]          k;
  logic [63:0]         thi;
  logic signed [63:0]  acc [3];

  // shared multiplier operands
  logic [33:0] mul_a, mul_b;
  logic        mul_n;

  // derived values
  logic signed [32:0] rx, ry, rz;
  logic [32:0]        ax, ay, az;
  logic [31:0]        wxm, wym, wzm;
  logic signed [68:0] sprod;
  logic signed [69:0] cdiff;
  logic signed [50:0] cnew;
  logic [64:0]        six_s2;
  logic [16:0]        n_eff;
  logic               last_idx;
  logic               c_big;
  logic [50:0]        cm0, cm1, cm2, cmk;
  logic [64:0]        term_p, term_c;
  logic               term_neg;
  logic [31:0]        e_poly;
  logic               load_fire, query_fire;
  logic [16:0]        slot_ext;

  assign in_ready   = (state == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign load_fire  = in_valid && in_ready && (in_data.action == vpv_pkg::ACT_LOAD);
  assign query_fire = in_valid && in_ready && (in_data.action == vpv_pkg::ACT_QUERY);
  assign slot_ext   = {9'd0, in_data.slot};

  // displacement and magnitudes
  assign rx  = {qx[31], qx} - {rec.pos_x[31], rec.pos_x};
  assign ry  = {qy[31], qy} - {rec.pos_y[31], rec.pos_y};
  assign rz  = {qz[31], qz} - {rec.pos_z[31], rec.pos_z};
  assign ax  = mag33(rx);
  assign ay  = mag33(ry);
  assign az  = mag33(rz);
  assign wxm = mag32(rec.vort_x);
  assign wym = mag32(rec.vort_y);
  assign wzm = mag32(rec.vort_z);

  // signed view of the product and the floored cross component
  assign sprod  = pneg ? -$signed({1'b0, prod}) : $signed({1'b0, prod});
  assign cdiff  = tmp - 70'(sprod);
  assign cnew   = 51'(cdiff >>> 16);
  assign six_s2 = {1'b0, prod[61:0], 2'b00} + {2'b00, prod[61:0], 1'b0};

  assign cm0 = mag51(cv[0]);
  assign cm1 = mag51(cv[1]);
  assign cm2 = mag51(cnew);
  assign c_big = (cm0[50:16] != '0) || (cm1[50:16] != '0) || (cm2[50:16] != '0);
  assign cmk   = mag51(cv[k]);

  // active count, clipped to the store depth
  assign n_eff    = (17'(count) > 17'(MAX_PARTICLES)) ? 17'(MAX_PARTICLES) : 17'(count);
  assign last_idx = (17'(idx) >= n_eff);

  // truncated series for exp(-y) before the squarings
  assign e_poly = vpv_pkg::ONE_Q30 - 32'(y) + 32'(y2 >> 1) - 32'(t6) + 32'(prod[35:19]);

  // term magnitude with cap
  assign term_p   = 65'(thi) + 65'(prod[67:16]);
  assign term_c   = (term_p > vpv_pkg::TERM_CAP) ? vpv_pkg::TERM_CAP : term_p;
  assign term_neg = fneg ^ cv[k][50];

  // operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    mul_n = 1'b0;
    unique case (state)
      S_RX:    begin mul_a = 34'(ax); mul_b = 34'(ax); end
      S_RY:    begin mul_a = 34'(ay); mul_b = 34'(ay); end
      S_RZ:    begin mul_a = 34'(az); mul_b = 34'(az); end
      S_RS:    begin mul_a = 34'(rec.radius); mul_b = 34'(rec.radius); end
      S_S2:    begin mul_a = 34'(ay); mul_b = 34'(wzm); mul_n = ry[32] ^ rec.vort_z[31]; end
      S_C0A:   begin mul_a = 34'(az); mul_b = 34'(wym); mul_n = rz[32] ^ rec.vort_y[31]; end
      S_C0B:   begin mul_a = 34'(az); mul_b = 34'(wxm); mul_n = rz[32] ^ rec.vort_x[31]; end
      S_C1A:   begin mul_a = 34'(ax); mul_b = 34'(wzm); mul_n = rx[32] ^ rec.vort_z[31]; end
      S_C1B:   begin mul_a = 34'(ax); mul_b = 34'(wym); mul_n = rx[32] ^ rec.vort_y[31]; end
      S_C2A:   begin mul_a = 34'(ay); mul_b = 34'(wxm); mul_n = ry[32] ^ rec.vort_x[31]; end
      S_C2B:   begin mul_a = 34'(wxm); mul_b = 34'(wxm); end
      S_W1:    begin mul_a = 34'(wym); mul_b = 34'(wym); end
      S_W2:    begin mul_a = 34'(wzm); mul_b = 34'(wzm); end
      S_W3:    begin mul_a = 34'(cm0[15:0]); mul_b = 34'(cm0[15:0]); end
      S_Q1:    begin mul_a = 34'(cm1[15:0]); mul_b = 34'(cm1[15:0]); end
      S_Q2:    begin mul_a = 34'(mag51(cv[2]) & 51'hFFFF); mul_b = 34'(mag51(cv[2]) & 51'hFFFF); end
      S_Q4:    begin mul_a = 34'(csum); mul_b = vpv_pkg::RHO_DIV; end
      S_E1:    begin mul_a = 34'(y); mul_b = 34'(y); end
      S_E2:    begin mul_a = 34'(prod[51:30]); mul_b = 34'(y); end
      S_E3:    begin mul_a = 34'(prod[47:30]); mul_b = 34'(y); end
      S_E4:    begin mul_a = 34'(y3 >> 1); mul_b = vpv_pkg::RECIP3; end
      S_E5:    begin mul_a = 34'(y4 >> 3); mul_b = vpv_pkg::RECIP3; end
      S_SQ:    begin mul_a = 34'(e); mul_b = 34'(e); end
      S_F:     begin mul_a = 34'(mag32(scale)); mul_b = 34'(e); end
      S_TA:    begin mul_a = 34'(fm); mul_b = 34'(cmk[48:16]); end
      S_TB:    begin mul_a = 34'(fm); mul_b = 34'(cmk[15:0]); end
      default: begin mul_a = '0; mul_b = '0; mul_n = 1'b0; end
    endcase
  end

  // shared multiplier, registered product
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    pneg <= mul_n;
  end

  // particle store: write on load transfer, registered read at the walk index
  always_ff @(posedge clk) begin
    if (load_fire && (slot_ext < 17'(MAX_PARTICLES))) begin
      mem[slot_ext[AW-1:0]] <= '{pos_x: in_data.coord_x, pos_y: in_data.coord_y,
                                 pos_z: in_data.coord_z, vort_x: in_data.vort_x,
                                 vort_y: in_data.vort_y, vort_z: in_data.vort_z,
                                 radius: in_data.radius, deleted: in_data.mark_deleted};
    end
    rec <= mem[idx[AW-1:0]];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= vpv_pkg::STRENGTH_RESET;
      count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        vpv_pkg::REG_STRENGTH_SCALE: scale <= cfg_data;
        vpv_pkg::REG_PARTICLE_COUNT: count <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (query_fire) begin
            qx     <= in_data.coord_x;
            qy     <= in_data.coord_y;
            qz     <= in_data.coord_z;
            acc[0] <= '0;
            acc[1] <= '0;
            acc[2] <= '0;
            idx    <= '0;
            state  <= in_data.mark_deleted ? S_FIN : S_FETCH;
          end
        end
        S_FETCH: state <= last_idx ? S_FIN : S_RX;
        S_RX: begin
          if (rec.deleted) begin
            idx   <= idx + 1'b1;
            state <= S_FETCH;
          end else begin
            state <= S_RY;
          end
        end
        S_RY: begin
          r2    <= prod;
          state <= S_RZ;
        end
        S_RZ: begin
          r2    <= r2 + prod;
          state <= S_RS;
        end
        S_RS: begin
          r2    <= r2 + prod;
          state <= S_S2;
        end
        S_S2: begin
          s2 <= prod[61:0];
          // cutoff, near-zero distance and zero vorticity all skip the entry
          if ((r2 > 68'(six_s2)) || (r2 < vpv_pkg::RLEN2_MIN) ||
              ((rec.vort_x == '0) && (rec.vort_y == '0) && (rec.vort_z == '0))) begin
            idx   <= idx + 1'b1;
            state <= S_FETCH;
          end else begin
            state <= S_C0A;
          end
        end
        S_C0A: begin tmp <= 70'(sprod); state <= S_C0B; end
        S_C0B: begin cv[0] <= cnew; state <= S_C1A; end
        S_C1A: begin tmp <= 70'(sprod); state <= S_C1B; end
        S_C1B: begin cv[1] <= cnew; state <= S_C2A; end
        S_C2A: begin tmp <= 70'(sprod); state <= S_C2B; end
        S_C2B: begin
          cv[2] <= cnew;
          if (c_big) begin
            rem   <= {r2[64:0], 23'd0};
            dsr   <= {1'b0, s2, 25'd0};
            y     <= '0;
            bitn  <= 5'd25;
            state <= S_DIV;
          end else begin
            state <= S_W1;
          end
        end
        S_W1: begin w2 <= 65'(prod); state <= S_W2; end
        S_W2: begin w2 <= w2 + 65'(prod); state <= S_W3; end
        S_W3: begin w2 <= w2 + 65'(prod); state <= S_Q1; end
        S_Q1: begin csum <= 36'(prod); state <= S_Q2; end
        S_Q2: begin csum <= csum + 36'(prod); state <= S_Q3; end
        S_Q3: begin csum <= csum + 36'(prod); state <= S_Q4; end
        S_Q4: state <= S_Q5;
        S_Q5: begin
          // rho test: sum of small cross squares against |w|^2 / 1e10
          if (prod > 68'(w2)) begin
            rem   <= {r2[64:0], 23'd0};
            dsr   <= {1'b0, s2, 25'd0};
            y     <= '0;
            bitn  <= 5'd25;
            state <= S_DIV;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_FETCH;
          end
        end
        S_DIV: begin
          // restoring division, one quotient bit a cycle
          if (rem >= dsr) begin
            rem     <= rem - dsr;
            y[bitn] <= 1'b1;
          end
          dsr <= dsr >> 1;
          if (bitn == 5'd0) begin
            state <= S_E1;
          end else begin
            bitn <= bitn - 1'b1;
          end
        end
        S_E1: state <= S_E2;
        S_E2: begin y2 <= prod[51:30]; state <= S_E3; end
        S_E3: begin y3 <= prod[47:30]; state <= S_E4; end
        S_E4: begin y4 <= prod[43:30]; state <= S_E5; end
        S_E5: begin t6 <= prod[35:19]; state <= S_E6; end
        S_E6: begin
          e     <= e_poly[30:0];
          sqn   <= '0;
          state <= S_SQ;
        end
        S_SQ: state <= S_SQW;
        S_SQW: begin
          e   <= prod[60:30];
          sqn <= sqn + 1'b1;
          state <= (sqn == 3'd5) ? S_F : S_SQ;
        end
        S_F: state <= S_FM;
        S_FM: begin
          fm    <= prod[61:30];
          fneg  <= scale[31];
          k     <= '0;
          state <= S_TA;
        end
        S_TA: state <= S_TB;
        S_TB: begin thi <= prod[63:0]; state <= S_TC; end
        S_TC: begin
          acc[k] <= acc[k] + (term_neg ? -$signed(64'(term_c)) : $signed(64'(term_c)));
          if (k == 2'd2) begin
            idx   <= idx + 1'b1;
            state <= S_FETCH;
          end else begin
            k     <= k + 1'b1;
            state <= S_TA;
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_data  <= '{vel_x: sat32(acc[0]), vel_y: sat32(acc[1]), vel_z: sat32(acc[2])};
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a query transfer occupies the sequencer
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (query_fire) |=> !in_ready)
    else $error("input taken during a query");

  // a finished query lands in the output register and frees the input
  a_fin_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && (!out_valid || out_ready)) |=> (out_valid && in_ready))
    else $error("result not delivered from finish");

  // a new result only comes from the finish step
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_FIN))
    else $error("result raised outside finish");

  // divider bit index stays inside the quotient
  a_div_bit: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (bitn <= 5'd25))
    else $error("divider bit index out of range");

endmodule

### bench/tb_top.sv
// self-checking testbench of the vortex particle velocity core
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import vpv_pkg::*;

  localparam int STORE_DEPTH = 256;
  localparam int WATCHDOG_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // shadow of the block's registers and particle store
  longint sh_scale = 65536;
  int sh_count = 0;
  logic signed [31:0] sh_px[STORE_DEPTH], sh_py[STORE_DEPTH], sh_pz[STORE_DEPTH];
  logic signed [31:0] sh_wx[STORE_DEPTH], sh_wy[STORE_DEPTH], sh_wz[STORE_DEPTH];
  logic [30:0] sh_rad[STORE_DEPTH];
  logic sh_del[STORE_DEPTH];

  out_item_t vel_expected_q[$];
  bit idle_on = 1'b1;
  int mismatches = 0;
  int n_loads = 0, n_queries = 0, n_results = 0, n_cfg = 0;
  int quiet_cycles = 0;

  vortex_particle_velocity_core u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // velocity arithmetic helpers
  function automatic logic [63:0] mag64(longint x);
    return (x < 0) ? 64'(-x) : 64'(x);
  endfunction

  function automatic longint floor16_diff(longint a, longint b);
    logic signed [127:0] t;
    t = a - b;
    return longint'(t >>> 16);
  endfunction

  function automatic logic [63:0] gauss_factor(logic [63:0] y);
    logic [63:0] y2, y3, y4, e;
    y2 = (y * y) >> 30;
    y3 = (y2 * y) >> 30;
    y4 = (y3 * y) >> 30;
    e = 64'(ONE_Q30) - y + (y2 >> 1) - y3 / 6 + y4 / 24;
    for (int k = 0; k < 6; k++) e = (e * e) >> 30;
    return e;
  endfunction

  function automatic longint scaled_term(longint f, longint c);
    logic [63:0] fm, cm, p;
    fm = mag64(f);
    cm = mag64(c);
    p = fm * (cm >> 16) + ((fm * (cm & 64'hFFFF)) >> 16);
    if (p > 64'(TERM_CAP)) p = 64'(TERM_CAP);
    return ((f < 0) != (c < 0)) ? -longint'(p) : longint'(p);
  endfunction

  function automatic logic signed [31:0] sat32(longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  // induced velocity at a query point over the shadow store
  function automatic out_item_t calc_velocity(in_item_t q);
    longint acc[3];
    longint rx, ry, rz, wx, wy, wz, f;
    longint c[3];
    logic [127:0] r2, six;
    logic [63:0] s2, w2, c2, y, e, am;
    bit pass;
    int n;
    out_item_t res;
    n = (sh_count > STORE_DEPTH) ? STORE_DEPTH : sh_count;
    acc[0] = 0; acc[1] = 0; acc[2] = 0;
    if (!q.mark_deleted) begin
      for (int i = 0; i < n; i++) begin
        if (sh_del[i]) continue;
        rx = longint'(q.coord_x) - longint'(sh_px[i]);
        ry = longint'(q.coord_y) - longint'(sh_py[i]);
        rz = longint'(q.coord_z) - longint'(sh_pz[i]);
        wx = longint'(sh_wx[i]); wy = longint'(sh_wy[i]); wz = longint'(sh_wz[i]);
        r2 = 128'(mag64(rx)) * mag64(rx) + 128'(mag64(ry)) * mag64(ry)
           + 128'(mag64(rz)) * mag64(rz);
        s2 = 64'(sh_rad[i]) * 64'(sh_rad[i]);
        six = 128'(s2) * 128'd6;
        if (r2 > six) continue;
        if (r2 < 128'(RLEN2_MIN)) continue;
        if (s2 == 0) continue;
        w2 = mag64(wx) * mag64(wx) + mag64(wy) * mag64(wy) + mag64(wz) * mag64(wz);
        if (w2 == 0) continue;
        c[0] = floor16_diff(ry * wz, rz * wy);
        c[1] = floor16_diff(rz * wx, rx * wz);
        c[2] = floor16_diff(rx * wy, ry * wx);
        pass = 1'b0;
        for (int k = 0; k < 3; k++) if (mag64(c[k]) >= 64'd65536) pass = 1'b1;
        if (!pass) begin
          c2 = mag64(c[0]) * mag64(c[0]) + mag64(c[1]) * mag64(c[1])
             + mag64(c[2]) * mag64(c[2]);
          pass = c2 > w2 / 64'(RHO_DIV);
        end
        if (!pass) continue;
        y = 64'((r2 << 23) / 128'(s2));
        e = gauss_factor(y);
        am = (mag64(sh_scale) * e) >> 30;
        f = (sh_scale < 0) ? -longint'(am) : longint'(am);
        for (int k = 0; k < 3; k++) acc[k] += scaled_term(f, c[k]);
      end
    end
    res.vel_x = sat32(acc[0]);
    res.vel_y = sat32(acc[1]);
    res.vel_z = sat32(acc[2]);
    return res;
  endfunction

  // apply one accepted item to the shadow and queue a query's result
  function automatic void track_item(in_item_t it);
    if (it.action == ACT_LOAD) begin
      sh_px[it.slot] = it.coord_x; sh_py[it.slot] = it.coord_y; sh_pz[it.slot] = it.coord_z;
      sh_wx[it.slot] = it.vort_x; sh_wy[it.slot] = it.vort_y; sh_wz[it.slot] = it.vort_z;
      sh_rad[it.slot] = it.radius;
      sh_del[it.slot] = it.mark_deleted;
      n_loads++;
    end else begin
      vel_expected_q.push_back(calc_velocity(it));
      n_queries++;
    end
  endfunction

  // one input transfer; valid is only lowered for a random gap before it
  task automatic send_item(in_item_t it);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    track_item(it);
  endtask

  // wait until every expected result has come and the core is idle
  task automatic drain;
    in_valid <= 1'b0;
    while (vel_expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_STRENGTH_SCALE) sh_scale = longint'($signed(value));
    else if (idx == REG_PARTICLE_COUNT) sh_count = int'(value[8:0]);
    n_cfg++;
    @(posedge clk);
  endtask

  function automatic int rnd_signed(int bits);
    return $signed($urandom) >>> (32 - bits);
  endfunction

  function automatic in_item_t mk_load(logic [7:0] slot, int px, int py, int pz,
                                       int wx, int wy, int wz, logic [30:0] rad, logic del);
    in_item_t it;
    it.action = ACT_LOAD; it.slot = slot;
    it.coord_x = px; it.coord_y = py; it.coord_z = pz;
    it.vort_x = wx; it.vort_y = wy; it.vort_z = wz;
    it.radius = rad; it.mark_deleted = del;
    return it;
  endfunction

  function automatic in_item_t mk_query(int px, int py, int pz, logic mark);
    in_item_t it;
    it = '0;
    it.action = ACT_QUERY; it.slot = 8'($urandom);
    it.coord_x = px; it.coord_y = py; it.coord_z = pz;
    it.vort_x = $urandom; it.vort_y = $urandom; it.vort_z = $urandom;
    it.radius = 31'($urandom); it.mark_deleted = mark;
    return it;
  endfunction

  function automatic in_item_t rand_particle(logic [7:0] slot);
    logic [30:0] rad;
    int wx, wy, wz, sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) rad = 0;
    else if (sel == 1) rad = 31'($urandom);
    else rad = 31'($urandom_range(1 << 12, 1 << 18));
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      wx = 0; wy = 0; wz = 0;
    end else if (sel == 1) begin
      wx = $urandom; wy = $urandom; wz = $urandom;
    end else begin
      wx = rnd_signed(20); wy = rnd_signed(20); wz = rnd_signed(20);
    end
    return mk_load(slot, rnd_signed(21), rnd_signed(21), rnd_signed(21), wx, wy, wz, rad,
                   $urandom_range(0, 7) == 0);
  endfunction

  // query point around stored particle j, inside or near its cutoff
  function automatic in_item_t query_near(int j);
    longint r, ox, oy, oz;
    r = longint'(sh_rad[j]);
    ox = longint'($urandom_range(0, 1000)) * r / 250 - 2 * r;
    oy = longint'($urandom_range(0, 1000)) * r / 250 - 2 * r;
    oz = longint'($urandom_range(0, 1000)) * r / 250 - 2 * r;
    return mk_query(int'(longint'(sh_px[j]) + ox), int'(longint'(sh_py[j]) + oy),
                    int'(longint'(sh_pz[j]) + oz), $urandom_range(0, 15) == 0);
  endfunction

  // receiver back-pressure in bursts
  always @(posedge clk) begin : rx_stall
    static int stall_left = 0;
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 19) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // compare every output transfer with the oldest expected velocity
  always @(posedge clk) begin : vel_check
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (vel_expected_q.size() == 0) begin
        if (mismatches < 10) $display("unexpected result %h", out_data);
        mismatches++;
      end else begin
        want = vel_expected_q.pop_front();
        if (want.vel_x !== out_data.vel_x || want.vel_y !== out_data.vel_y ||
            want.vel_z !== out_data.vel_z) begin
          if (mismatches < 10)
            $display("velocity mismatch: expected x=%0d y=%0d z=%0d got x=%0d y=%0d z=%0d",
                     want.vel_x, want.vel_y, want.vel_z,
                     out_data.vel_x, out_data.vel_y, out_data.vel_z);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // every slot is written before any query can read it
  task automatic test_fill_store;
    for (int s = 0; s < STORE_DEPTH; s++) send_item(rand_particle(8'(s)));
    drain();
  endtask

  task automatic test_directed;
    // empty count, reset strength
    send_item(mk_query(0, 0, 0, 1'b0));
    drain();
    // hand-built cluster in slots 0..4, and slot 255
    write_reg(REG_PARTICLE_COUNT, 32'd5);
    send_item(mk_load(8'd0, 0, 0, 0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                      31'h0001_0000, 1'b0));
    send_item(mk_load(8'd1, 32'h0000_8000, 0, 0, 0, 0, 0, 31'h0001_0000, 1'b0));
    send_item(mk_load(8'd2, 0, 32'h0000_4000, 0, 32'h0100_0000, 0, 0, 31'h0000_0000, 1'b0));
    send_item(mk_load(8'd3, 0, 0, 32'h0000_4000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                      31'h0002_0000, 1'b1));
    send_item(mk_load(8'd4, 32'h0000_2000, 32'h0000_2000, 0, 32'h7FFF_FFFF, 32'h8000_0000,
                      32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0));
    send_item(mk_load(8'd255, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_1000,
                      32'h0000_1000, 32'h0000_1000, 31'h7FFF_FFFF, 1'b0));
    // point on a particle, near, marked, far beyond the cutoff
    send_item(mk_query(0, 0, 0, 1'b0));
    send_item(mk_query(32'h0000_4000, 32'h0000_3000, 32'h0000_1000, 1'b0));
    send_item(mk_query(32'h0000_4000, 32'h0000_3000, 32'h0000_1000, 1'b1));
    send_item(mk_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0));
    send_item(mk_query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0));
    drain();
    // extreme strengths, then a zero strength
    write_reg(REG_STRENGTH_SCALE, 32'h7FFF_FFFF);
    send_item(mk_query(32'h0001_0000, 32'h0000_3000, 32'h0000_1000, 1'b0));
    drain();
    write_reg(REG_STRENGTH_SCALE, 32'h8000_0000);
    send_item(mk_query(32'h0001_0000, 32'h0000_3000, 32'h0000_1000, 1'b0));
    drain();
    write_reg(REG_STRENGTH_SCALE, 32'h0000_0000);
    send_item(mk_query(32'h0000_4000, 32'h0000_3000, 32'h0000_1000, 1'b0));
    drain();
    // whole store, and a count above the store depth
    write_reg(REG_STRENGTH_SCALE, 32'h0001_0000);
    write_reg(REG_PARTICLE_COUNT, 32'd256);
    send_item(mk_query(32'h7FFF_0000, 32'h8000_0000, 32'h7FFF_0000, 1'b0));
    drain();
    write_reg(REG_PARTICLE_COUNT, 32'h1FF);
    send_item(mk_query(32'h0000_2000, 32'h0000_2000, 0, 1'b0));
    drain();
  endtask

  task automatic test_random(int phases);
    int cnt, items, sel, j;
    for (int p = 0; p < phases; p++) begin
      if (p >= phases - 5) idle_on = 1'b0;
      sel = $urandom_range(0, 9);
      if (sel == 0) write_reg(REG_STRENGTH_SCALE, $urandom);
      else if (sel == 1) write_reg(REG_STRENGTH_SCALE, 32'h0001_0000);
      else write_reg(REG_STRENGTH_SCALE, rnd_signed(20));
      big_phase: begin
        cnt = ($urandom_range(0, 24) == 0) ? 256 : $urandom_range(1, 8);
        items = (cnt == 256) ? 4 : 45;
      end
      write_reg(REG_PARTICLE_COUNT, cnt);
      for (int k = 0; k < items; k++) begin
        sel = $urandom_range(0, 9);
        j = $urandom_range(0, ((cnt > 8) ? 8 : cnt) - 1);
        if (sel < 3) send_item(rand_particle(8'($urandom_range(0, 15))));
        else if (sel == 3) send_item(rand_particle(8'($urandom)));
        else if (sel == 4) send_item(mk_query($urandom, $urandom, $urandom, $urandom_range(0, 1)));
        else send_item(query_near(j));
      end
      drain();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_fill_store();
    test_directed();
    test_random(30);
    drain();
    $display("covered %0d loads, %0d queries, %0d results, %0d register writes",
             n_loads, n_queries, n_results, n_cfg);
    $display("strength and count extremes, marked points, deleted and degenerate particles");
    if (mismatches == 0 && vel_expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### files.f
design/vpv_pkg.sv
design/vortex_particle_velocity_core.sv
bench/tb_top.sv
